// ----- rtl/core/tlc_pkg.sv -----
// Shared types and constants of the text literal type classifier.
`default_nettype none

package tlc_pkg;

  // Depth of the queue between the character decoder and the automaton.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Character classes seen by the automaton.
  typedef enum logic [4:0] {
    CC_OTHER,
    CC_DIGIT,
    CC_MINUS,
    CC_PLUS,
    CC_DOT,
    CC_COLON,
    CC_SPACE,
    CC_QUOTE,
    CC_T,
    CC_R,
    CC_U,
    CC_E,
    CC_F,
    CC_A,
    CC_L,
    CC_S,
    CC_NUL,
    CC_NONE
  } char_class_e;

  // Result codes.
  typedef enum logic [2:0] {
    TC_UNKNOWN   = 3'd0,
    TC_STRING    = 3'd1,
    TC_INT       = 3'd2,
    TC_FLOAT     = 3'd3,
    TC_TIMESTAMP = 3'd4,
    TC_DATE      = 3'd5,
    TC_BOOL      = 3'd6
  } type_code_e;

  // One decoded beat as it travels through the queue.
  typedef struct packed {
    char_class_e cls;
    logic        last;
  } item_t;

  // Queue head as seen by the automaton.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

`default_nettype wire

// ----- rtl/core/text_literal_type_classifier.sv -----
// A field's last beat passes through the queue and then sets the output register, which holds the result.
// Throughput: one character beat per cycle while the queue has room, set by the one-step automaton.
// A two-beat queue separates the character decoder from the automaton. A field end waits
// at the queue head while the previous type code is unread; one more beat then fills the
// queue and the input stalls until that result is taken.
// Reset: asynchronous, active low; clears the queue, the automaton and the output valid.
`default_nettype none

module text_literal_type_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       field_end_i,
  input  logic       no_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] type_code_o
);
  import tlc_pkg::*;

  logic    q_ready, q_push, q_pop;
  item_t   q_item;
  q_head_t q_head;

  // Character decoder.
  tlc_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_byte_i (text_byte_i),
    .field_end_i (field_end_i),
    .no_char_i   (no_char_i),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_item_o    (q_item)
  );

  // Decoupling queue.
  tlc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item),
    .ready_o (q_ready),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  // Recognizer and output register.
  tlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .type_code_o (type_code_o)
  );

`ifndef SYNTH
  // A full queue always has a beat waiting at its head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_head.valid)
    else $error("queue reports full with no beat at its head");

  // A field end never leaves the queue while an unread result is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_head.item.last) |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before it was taken");

  // A result is only produced by a field end leaving the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(q_pop && q_head.item.last))
    else $error("result appeared without a field end");

  // Codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (type_code_o <= TC_BOOL))
    else $error("undefined type code");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/tlc_front.sv -----
// Input side: decodes each character beat into a character class.
`default_nettype none

module tlc_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    text_byte_i,
  input  logic          field_end_i,
  input  logic          no_char_i,
  input  logic          q_ready_i,
  output logic          q_push_o,
  output tlc_pkg::item_t q_item_o
);
  import tlc_pkg::*;

  char_class_e cls;

  // Map the byte onto the small alphabet of the automaton.
  always_comb begin
    if (no_char_i) begin
      cls = CC_NONE;
    end else begin
      unique case (text_byte_i) inside
        [8'h30:8'h39]: cls = CC_DIGIT;
        8'h00:         cls = CC_NUL;
        "-":           cls = CC_MINUS;
        "+":           cls = CC_PLUS;
        ".":           cls = CC_DOT;
        ":":           cls = CC_COLON;
        " ":           cls = CC_SPACE;
        "\"":          cls = CC_QUOTE;
        "t":           cls = CC_T;
        "r":           cls = CC_R;
        "u":           cls = CC_U;
        "e":           cls = CC_E;
        "f":           cls = CC_F;
        "a":           cls = CC_A;
        "l":           cls = CC_L;
        "s":           cls = CC_S;
        default:       cls = CC_OTHER;
      endcase
    end
  end

  // The queue absorbs the beat whenever it has room.
  assign in_ready_o    = q_ready_i;
  assign q_push_o      = in_valid_i & q_ready_i;
  assign q_item_o.cls  = cls;
  assign q_item_o.last = field_end_i;

endmodule

`default_nettype wire

// ----- rtl/core/tlc_fifo.sv -----
// Short queue of decoded beats between the decoder and the automaton.
`default_nettype none

module tlc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tlc_pkg::item_t   item_i,
  output logic             ready_o,
  output tlc_pkg::q_head_t head_o,
  input  logic             pop_i
);
  import tlc_pkg::*;

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign ready_o      = (cnt_q != QCntW'(QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tlc_back.sv -----
// Automaton side: steps the literal recognizer and registers the type code.
`default_nettype none

module tlc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlc_pkg::q_head_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       type_code_o
);
  import tlc_pkg::*;

  typedef enum logic [39:0] {
    ST_START = 40'd1 << 0,  ST_DEAD  = 40'd1 << 1,  ST_NEG   = 40'd1 << 2,
    ST_D1    = 40'd1 << 3,  ST_D2    = 40'd1 << 4,  ST_D3    = 40'd1 << 5,
    ST_D4    = 40'd1 << 6,  ST_INT   = 40'd1 << 7,  ST_DOT   = 40'd1 << 8,
    ST_FRAC  = 40'd1 << 9,  ST_Y     = 40'd1 << 10, ST_M1    = 40'd1 << 11,
    ST_M2    = 40'd1 << 12, ST_MD    = 40'd1 << 13, ST_DD1   = 40'd1 << 14,
    ST_DATE  = 40'd1 << 15, ST_SP    = 40'd1 << 16, ST_H1    = 40'd1 << 17,
    ST_H2    = 40'd1 << 18, ST_HC    = 40'd1 << 19, ST_MI1   = 40'd1 << 20,
    ST_MI2   = 40'd1 << 21, ST_MC    = 40'd1 << 22, ST_S1    = 40'd1 << 23,
    ST_TS    = 40'd1 << 24, ST_TDOT  = 40'd1 << 25, ST_TFRAC = 40'd1 << 26,
    ST_Z0    = 40'd1 << 27, ST_Z1    = 40'd1 << 28, ST_Z2    = 40'd1 << 29,
    ST_Z3    = 40'd1 << 30, ST_Z4    = 40'd1 << 31, ST_T1    = 40'd1 << 32,
    ST_T2    = 40'd1 << 33, ST_T3    = 40'd1 << 34, ST_F1    = 40'd1 << 35,
    ST_F2    = 40'd1 << 36, ST_F3    = 40'd1 << 37, ST_F4    = 40'd1 << 38,
    ST_BOOL  = 40'd1 << 39
  } scan_state_e;

  scan_state_e state_q, state_d, state_nx;
  logic        opened_q, opened_d;
  logic        latest_q, latest_d;
  logic        ended_q, ended_d;
  logic        out_valid_q, out_valid_d;
  type_code_e  type_code_q, type_code_d;
  type_code_e  result;
  char_class_e c;
  logic        dig, sgn, step;

  assign c   = head_i.item.cls;
  assign dig = (c == CC_DIGIT);
  assign sgn = (c == CC_PLUS) || (c == CC_MINUS);

  // A last beat waits while the output register is still occupied and not being read.
  assign pop_o = head_i.valid && (!head_i.item.last || !out_valid_q || out_ready_i);
  assign step  = pop_o && (c != CC_NONE) && !ended_q;

  // Next state of the recognizer for one character.
  always_comb begin
    state_nx = ST_DEAD;
    unique case (state_q)
      ST_START: begin
        if (c == CC_MINUS)    state_nx = ST_NEG;
        else if (dig)         state_nx = ST_D1;
        else if (c == CC_DOT) state_nx = ST_DOT;
        else if (c == CC_T)   state_nx = ST_T1;
        else if (c == CC_F)   state_nx = ST_F1;
      end
      ST_NEG: begin
        if (dig)              state_nx = ST_INT;
        else if (c == CC_DOT) state_nx = ST_DOT;
      end
      ST_D1: begin
        if (dig)              state_nx = ST_D2;
        else if (c == CC_DOT) state_nx = ST_DOT;
      end
      ST_D2: begin
        if (dig)              state_nx = ST_D3;
        else if (c == CC_DOT) state_nx = ST_DOT;
      end
      ST_D3: begin
        if (dig)              state_nx = ST_D4;
        else if (c == CC_DOT) state_nx = ST_DOT;
      end
      ST_D4: begin
        if (dig)                state_nx = ST_INT;
        else if (c == CC_MINUS) state_nx = ST_Y;
        else if (c == CC_DOT)   state_nx = ST_DOT;
      end
      ST_INT: begin
        if (dig)              state_nx = ST_INT;
        else if (c == CC_DOT) state_nx = ST_DOT;
      end
      ST_DOT, ST_FRAC: if (dig) state_nx = ST_FRAC;
      ST_Y:   if (dig) state_nx = ST_M1;
      ST_M1:  if (dig) state_nx = ST_M2;
      ST_M2:  if (c == CC_MINUS) state_nx = ST_MD;
      ST_MD:  if (dig) state_nx = ST_DD1;
      ST_DD1: if (dig) state_nx = ST_DATE;
      ST_DATE: if (c == CC_SPACE) state_nx = ST_SP;
      ST_SP:  if (dig) state_nx = ST_H1;
      ST_H1:  if (dig) state_nx = ST_H2;
      ST_H2:  if (c == CC_COLON) state_nx = ST_HC;
      ST_HC:  if (dig) state_nx = ST_MI1;
      ST_MI1: if (dig) state_nx = ST_MI2;
      ST_MI2: if (c == CC_COLON) state_nx = ST_MC;
      ST_MC:  if (dig) state_nx = ST_S1;
      ST_S1:  if (dig) state_nx = ST_TS;
      ST_TS: begin
        if (c == CC_DOT) state_nx = ST_TDOT;
        else if (sgn)    state_nx = ST_Z0;
      end
      ST_TDOT: if (dig) state_nx = ST_TFRAC;
      ST_TFRAC: begin
        if (dig)      state_nx = ST_TFRAC;
        else if (sgn) state_nx = ST_Z0;
      end
      ST_Z0: if (dig) state_nx = ST_Z1;
      ST_Z1: if (dig) state_nx = ST_Z2;
      ST_Z2: if (dig) state_nx = ST_Z3;
      ST_Z3: if (dig) state_nx = ST_Z4;
      ST_T1: if (c == CC_R) state_nx = ST_T2;
      ST_T2: if (c == CC_U) state_nx = ST_T3;
      ST_T3: if (c == CC_E) state_nx = ST_BOOL;
      ST_F1: if (c == CC_A) state_nx = ST_F2;
      ST_F2: if (c == CC_L) state_nx = ST_F3;
      ST_F3: if (c == CC_S) state_nx = ST_F4;
      ST_F4: if (c == CC_E) state_nx = ST_BOOL;
      default: state_nx = ST_DEAD;
    endcase
  end

  // Apply the character, then classify and restart at the end of a field.
  always_comb begin
    state_d     = state_q;
    opened_d    = opened_q;
    latest_d    = latest_q;
    ended_d     = ended_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    type_code_d = type_code_q;
    result      = TC_UNKNOWN;

    if (step) begin
      if (c == CC_NUL) begin
        ended_d = 1'b1;
      end else begin
        if (state_q == ST_START) begin
          opened_d = (c == CC_QUOTE);
        end
        latest_d = (c == CC_QUOTE);
        state_d  = state_nx;
      end
    end

    if (opened_d) begin
      result = latest_d ? TC_STRING : TC_UNKNOWN;
    end else begin
      case (state_d)
        ST_D1, ST_D2, ST_D3, ST_D4, ST_INT:  result = TC_INT;
        ST_FRAC:                             result = TC_FLOAT;
        ST_TS, ST_TFRAC, ST_Z2, ST_Z4:       result = TC_TIMESTAMP;
        ST_DATE:                             result = TC_DATE;
        ST_BOOL:                             result = TC_BOOL;
        default:                             result = TC_UNKNOWN;
      endcase
    end

    if (pop_o && head_i.item.last) begin
      out_valid_d = 1'b1;
      type_code_d = result;
      state_d     = ST_START;
      opened_d    = 1'b0;
      latest_d    = 1'b0;
      ended_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      opened_q    <= 1'b0;
      latest_q    <= 1'b0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      opened_q    <= opened_d;
      latest_q    <= latest_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    type_code_q <= type_code_d;
  end

  assign out_valid_o = out_valid_q;
  assign type_code_o = type_code_q;

endmodule

`default_nettype wire

// ----- tb/text_literal_type_classifier_checker.sv -----
// Checker for the literal type classifier: predicts each field's type code and compares results.
module text_literal_type_classifier_checker
  import tlc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  text_byte_i,
  input  logic        field_end_i,
  input  logic        no_char_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  type_code_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Scan states of the literal recognizer.
  typedef enum logic [5:0] {
    SC_START, SC_DEAD, SC_SIGN, SC_LEAD1, SC_LEAD2, SC_LEAD3, SC_LEAD4, SC_INT,
    SC_POINT, SC_FRAC, SC_YEAR, SC_MON1, SC_MON2, SC_MON_DASH, SC_DAY1, SC_DATE,
    SC_GAP, SC_HR1, SC_HR2, SC_HR_COLON, SC_MIN1, SC_MIN2, SC_MIN_COLON, SC_SEC1,
    SC_STAMP, SC_STAMP_POINT, SC_STAMP_FRAC, SC_ZONE_SIGN, SC_ZONE1, SC_ZONE2,
    SC_ZONE3, SC_ZONE4, SC_T, SC_TR, SC_TRU, SC_F, SC_FA, SC_FAL, SC_FALS, SC_BOOL
  } scan_e;

  scan_e       scan;
  logic        opened_quote;
  logic        closing_quote;
  logic        text_done;
  int unsigned fail_count;
  type_code_e  expected_codes[$];

  // One step of the recognizer; anything not listed falls into the dead state.
  function automatic scan_e next_scan(scan_e s, logic [7:0] c);
    logic  dig;
    logic  sgn;
    scan_e nxt;
    dig = (c >= "0") && (c <= "9");
    sgn = (c == "+") || (c == "-");
    nxt = SC_DEAD;
    case (s)
      SC_START: begin
        if (c == "-") nxt = SC_SIGN;
        else if (dig) nxt = SC_LEAD1;
        else if (c == ".") nxt = SC_POINT;
        else if (c == "t") nxt = SC_T;
        else if (c == "f") nxt = SC_F;
      end
      SC_SIGN, SC_INT: begin
        if (dig) nxt = SC_INT;
        else if (c == ".") nxt = SC_POINT;
      end
      SC_LEAD1: begin
        if (dig) nxt = SC_LEAD2;
        else if (c == ".") nxt = SC_POINT;
      end
      SC_LEAD2: begin
        if (dig) nxt = SC_LEAD3;
        else if (c == ".") nxt = SC_POINT;
      end
      SC_LEAD3: begin
        if (dig) nxt = SC_LEAD4;
        else if (c == ".") nxt = SC_POINT;
      end
      SC_LEAD4: begin
        if (dig) nxt = SC_INT;
        else if (c == "-") nxt = SC_YEAR;
        else if (c == ".") nxt = SC_POINT;
      end
      SC_POINT, SC_FRAC: if (dig) nxt = SC_FRAC;
      SC_YEAR:      if (dig) nxt = SC_MON1;
      SC_MON1:      if (dig) nxt = SC_MON2;
      SC_MON2:      if (c == "-") nxt = SC_MON_DASH;
      SC_MON_DASH:  if (dig) nxt = SC_DAY1;
      SC_DAY1:      if (dig) nxt = SC_DATE;
      SC_DATE:      if (c == " ") nxt = SC_GAP;
      SC_GAP:       if (dig) nxt = SC_HR1;
      SC_HR1:       if (dig) nxt = SC_HR2;
      SC_HR2:       if (c == ":") nxt = SC_HR_COLON;
      SC_HR_COLON:  if (dig) nxt = SC_MIN1;
      SC_MIN1:      if (dig) nxt = SC_MIN2;
      SC_MIN2:      if (c == ":") nxt = SC_MIN_COLON;
      SC_MIN_COLON: if (dig) nxt = SC_SEC1;
      SC_SEC1:      if (dig) nxt = SC_STAMP;
      SC_STAMP: begin
        if (c == ".") nxt = SC_STAMP_POINT;
        else if (sgn) nxt = SC_ZONE_SIGN;
      end
      SC_STAMP_POINT: if (dig) nxt = SC_STAMP_FRAC;
      SC_STAMP_FRAC: begin
        if (dig) nxt = SC_STAMP_FRAC;
        else if (sgn) nxt = SC_ZONE_SIGN;
      end
      SC_ZONE_SIGN: if (dig) nxt = SC_ZONE1;
      SC_ZONE1:     if (dig) nxt = SC_ZONE2;
      SC_ZONE2:     if (dig) nxt = SC_ZONE3;
      SC_ZONE3:     if (dig) nxt = SC_ZONE4;
      SC_T:         if (c == "r") nxt = SC_TR;
      SC_TR:        if (c == "u") nxt = SC_TRU;
      SC_TRU:       if (c == "e") nxt = SC_BOOL;
      SC_F:         if (c == "a") nxt = SC_FA;
      SC_FA:        if (c == "l") nxt = SC_FAL;
      SC_FAL:       if (c == "s") nxt = SC_FALS;
      SC_FALS:      if (c == "e") nxt = SC_BOOL;
      default:      nxt = SC_DEAD;
    endcase
    return nxt;
  endfunction

  // Type of a finished field. A field that opened with a quote is a string or nothing.
  function automatic type_code_e field_type(scan_e s, logic quoted, logic closed);
    if (quoted) return closed ? TC_STRING : TC_UNKNOWN;
    case (s)
      SC_LEAD1, SC_LEAD2, SC_LEAD3, SC_LEAD4, SC_INT:     return TC_INT;
      SC_FRAC:                                            return TC_FLOAT;
      SC_STAMP, SC_STAMP_FRAC, SC_ZONE2, SC_ZONE4:        return TC_TIMESTAMP;
      SC_DATE:                                            return TC_DATE;
      SC_BOOL:                                            return TC_BOOL;
      default:                                            return TC_UNKNOWN;
    endcase
  endfunction

  // Results are checked before the input beat of the same edge is predicted, so a
  // stray result can never match an expectation that was only just queued.
  always @(posedge clk_i or negedge rst_ni) begin : predict_and_check
    type_code_e want;
    if (!rst_ni) begin
      scan          = SC_START;
      opened_quote  = 1'b0;
      closing_quote = 1'b0;
      text_done     = 1'b0;
      fail_count    = 0;
      expected_codes.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_codes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none, actual %0d",
                   $time, type_code_i);
        end else begin
          want = expected_codes.pop_front();
          if (type_code_i !== want) begin
            fail_count++;
            $display("%0t: type code mismatch, expected %0d (%s), actual %0d",
                     $time, want, want.name(), type_code_i);
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        // A zero byte ends the text; the rest of the field is ignored.
        if (!no_char_i && !text_done) begin
          if (text_byte_i == 8'h00) begin
            text_done = 1'b1;
          end else begin
            if (scan == SC_START) opened_quote = (text_byte_i == "\"");
            closing_quote = (text_byte_i == "\"");
            scan = next_scan(scan, text_byte_i);
          end
        end
        if (field_end_i) begin
          expected_codes.push_back(field_type(scan, opened_quote, closing_quote));
          scan          = SC_START;
          opened_quote  = 1'b0;
          closing_quote = 1'b0;
          text_done     = 1'b0;
        end
      end
    end
    mismatch_count_o <= fail_count;
    pending_o        <= expected_codes.size();
  end

endmodule

// ----- tb/text_literal_type_classifier_tb.sv -----
// Top of the literal type classifier testbench: clock, reset, field stimulus and verdict.
module text_literal_type_classifier_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 300000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  text_byte;
  logic        field_end;
  logic        no_char;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  type_code;
  int unsigned mismatches;
  int unsigned pending;

  int unsigned send_idle_pct = 20;
  int unsigned recv_idle_pct = 82;
  int unsigned hold_cycles   = 0;
  int unsigned beats_sent    = 0;
  int unsigned cycle_count   = 0;
  logic [7:0]  field_chars[$];

  text_literal_type_classifier uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .text_byte_i (text_byte),
    .field_end_i (field_end),
    .no_char_i   (no_char),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .type_code_o (type_code)
  );

  text_literal_type_classifier_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .text_byte_i      (text_byte),
    .field_end_i      (field_end),
    .no_char_i        (no_char),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .type_code_i      (type_code),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one beat and hold it until it is taken.
  task automatic drive_beat(input logic [7:0] ch, input logic last, input logic none);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= ch;
    field_end <= last;
    no_char   <= none;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Send the characters of field_chars as one field. The end mark rides either on the
  // last character or on a trailing empty beat; empty beats are also sprinkled inside.
  task automatic play_field();
    int unsigned n;
    logic        end_on_gap;
    n = field_chars.size();
    end_on_gap = (n == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) drive_beat(8'($urandom_range(255)), 1'b0, 1'b1);
      drive_beat(field_chars[i], !end_on_gap && (i == n - 1), 1'b0);
    end
    if (end_on_gap) drive_beat(8'($urandom_range(255)), 1'b1, 1'b1);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) field_chars.push_back(s[i]);
  endtask

  task automatic push_digits(input int unsigned n);
    repeat (n) field_chars.push_back(8'("0" + $urandom_range(9)));
  endtask

  task automatic directed_field(input string s);
    field_chars.delete();
    push_text(s);
    play_field();
  endtask

  task automatic push_date();
    push_digits(4);
    push_text("-");
    push_digits(2);
    push_text("-");
    push_digits(2);
  endtask

  // Mostly well-formed literals with random content, the rest noise or damaged text.
  task automatic build_random_field();
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    field_chars.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      // Quoted string, sometimes a lone quote or missing its closing quote.
      push_text("\"");
      if ($urandom_range(7) != 0) begin
        n = $urandom_range(5);
        repeat (n) field_chars.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(4) != 0) push_text("\"");
      end
    end else if (kind < 26) begin
      if ($urandom_range(1)) push_text("-");
      push_digits($urandom_range(1, 8));
    end else if (kind < 40) begin
      // Float; now and then a doubled sign or no digits after the point.
      n = $urandom_range(9);
      if (n < 4) push_text("-");
      if (n == 0) push_text("-");
      push_digits($urandom_range(0, 4));
      push_text(".");
      push_digits(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4));
    end else if (kind < 52) begin
      push_date();
    end else if (kind < 72) begin
      push_date();
      push_text(" ");
      push_digits(2);
      push_text(":");
      push_digits(2);
      push_text(":");
      push_digits(2);
      if ($urandom_range(1)) begin
        push_text(".");
        push_digits($urandom_range(1, 5));
      end
      // Zone of two or four digits, sometimes none or a bad length.
      n = $urandom_range(7);
      if (n >= 2) begin
        push_text($urandom_range(1) ? "+" : "-");
        case (n)
          2, 3, 4: push_digits(2);
          5, 6:    push_digits(4);
          default: push_digits($urandom_range(1) ? 1 : 3);
        endcase
      end
    end else if (kind < 82) begin
      n = $urandom_range(9);
      if (n < 4) push_text("true");
      else if (n < 8) push_text("false");
      else if (n == 8) begin
        push_text("false");
        repeat (5 - $urandom_range(1, 4)) void'(field_chars.pop_back());
      end else begin
        push_text($urandom_range(1) ? "true" : "false");
        field_chars.push_back(8'($urandom_range("a", "z")));
      end
    end else begin
      n = $urandom_range(6);
      repeat (n) field_chars.push_back(8'($urandom_range(255)));
    end

    // Damage some fields: overwrite, cut short, plant a zero byte or add a tail.
    if (field_chars.size() > 0 && $urandom_range(99) < 15) begin
      pos = $urandom_range(field_chars.size() - 1);
      case ($urandom_range(3))
        0: field_chars[pos] = 8'($urandom_range(255));
        1: while (field_chars.size() > pos) void'(field_chars.pop_back());
        2: field_chars.insert(pos, 8'h00);
        default: field_chars.push_back(8'($urandom_range(32, 126)));
      endcase
    end
  endtask

  task automatic random_fields_until(input int unsigned total);
    while (beats_sent < total) begin
      build_random_field();
      play_field();
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    text_byte <= 8'h00;
    field_end <= 1'b0;
    no_char   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed fields: every literal form, near misses and the special cases.
    directed_field("\"hello\"");
    directed_field("\"");
    directed_field("\"abc");
    directed_field("\"a\"b");
    directed_field("-42");
    directed_field("12345678");
    directed_field("3.14");
    directed_field("-.5");
    directed_field("--1.5");
    directed_field("1.");
    directed_field("2024-02-29");
    directed_field("2024-02-29 23:59:59");
    directed_field("1999-12-31 00:00:00.123-05");
    directed_field("2000-01-01 12:00:00+0530");
    directed_field("2000-01-01 12:00:00+053");
    directed_field("true");
    directed_field("false");
    directed_field("tru");
    directed_field("truex");

    // Empty field.
    field_chars.delete();
    play_field();

    // Zero byte cuts the text short, also right at the start.
    field_chars.delete();
    push_text("12");
    field_chars.push_back(8'h00);
    push_text("ab");
    play_field();
    field_chars.delete();
    field_chars.push_back(8'h00);
    push_text("\"");
    play_field();
    field_chars.delete();
    push_text("\"a");
    field_chars.push_back(8'h00);
    push_text("\"");
    play_field();

    // High bytes are ordinary characters.
    field_chars.delete();
    field_chars.push_back(8'hFF);
    play_field();
    field_chars.delete();
    push_text("7");
    field_chars.push_back(8'h80);
    play_field();

    random_fields_until(700);

    send_idle_pct = 82;
    recv_idle_pct = 20;
    random_fields_until(1400);

    // No idling, starting with a long result stall while beats keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    hold_cycles = 400;
    @(posedge clk);
    repeat (40) drive_beat(8'("0" + $urandom_range(9)), 1'b1, 1'b0);
    random_fields_until(2100);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
